// ===== hw/rtl/marching_squares_contour_top_macros.svh =====
// assertion macros for the marching squares contour block
// expects clk and arst_n in the scope of each use
`ifndef MARCHING_SQUARES_CONTOUR_TOP_MACROS_SVH
`define MARCHING_SQUARES_CONTOUR_TOP_MACROS_SVH

// same-cycle implication
`define MSC_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication
`define MSC_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ===== hw/rtl/msc_pkg.sv =====
// shared types, constants and tables for the marching squares contour block
// no dependencies
`default_nettype none

package msc_pkg;

	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 1024;
	localparam int FRAC_BITS  = 8;
	localparam int SAMP_W     = 16;
	localparam int CFG_W      = 11;
	localparam int COL_W      = 10;
	localparam int ROW_W      = 10;
	localparam int COORD_W    = 18;
	localparam int CUT_W      = FRAC_BITS + 1;
	localparam int DEN_W      = SAMP_W + 2;
	localparam int DIV_STEPS  = FRAC_BITS + 1;
	localparam int STEP_W     = 4;

	typedef logic [1:0] edge_id_t;
	localparam edge_id_t EDGE_LEFT   = 2'd0;
	localparam edge_id_t EDGE_TOP    = 2'd1;
	localparam edge_id_t EDGE_RIGHT  = 2'd2;
	localparam edge_id_t EDGE_BOTTOM = 2'd3;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EVAL,
		ST_DLOAD,
		ST_DRUN,
		ST_SEG0,
		ST_SEG1
	} msc_state_t;

	typedef struct packed {
		logic take;
		logic eval;
		logic div_load;
		logic div_step;
		logic div_store;
		logic load_seg;
		logic seg_sel;
	} msc_cmd_t;

	typedef struct packed {
		logic has_seg;
		logic two_seg;
		logic div_last;
		logic edge_last;
		logic out_busy;
	} msc_status_t;

	// endpoint edges of up to two segments, first segment in the top bits
	function automatic logic [7:0] seg_ends(input logic [3:0] code);
		logic [7:0] e;
		case (code)
			4'd1:    e = {EDGE_LEFT,   EDGE_TOP,    EDGE_LEFT,   EDGE_LEFT};
			4'd2:    e = {EDGE_TOP,    EDGE_RIGHT,  EDGE_LEFT,   EDGE_LEFT};
			4'd3:    e = {EDGE_LEFT,   EDGE_RIGHT,  EDGE_LEFT,   EDGE_LEFT};
			4'd4:    e = {EDGE_BOTTOM, EDGE_LEFT,   EDGE_LEFT,   EDGE_LEFT};
			4'd5:    e = {EDGE_BOTTOM, EDGE_TOP,    EDGE_LEFT,   EDGE_LEFT};
			4'd6:    e = {EDGE_TOP,    EDGE_LEFT,   EDGE_BOTTOM, EDGE_RIGHT};
			4'd7:    e = {EDGE_BOTTOM, EDGE_RIGHT,  EDGE_LEFT,   EDGE_LEFT};
			4'd8:    e = {EDGE_RIGHT,  EDGE_BOTTOM, EDGE_LEFT,   EDGE_LEFT};
			4'd9:    e = {EDGE_LEFT,   EDGE_TOP,    EDGE_RIGHT,  EDGE_BOTTOM};
			4'd10:   e = {EDGE_TOP,    EDGE_BOTTOM, EDGE_LEFT,   EDGE_LEFT};
			4'd11:   e = {EDGE_LEFT,   EDGE_BOTTOM, EDGE_LEFT,   EDGE_LEFT};
			4'd12:   e = {EDGE_RIGHT,  EDGE_LEFT,   EDGE_LEFT,   EDGE_LEFT};
			4'd13:   e = {EDGE_RIGHT,  EDGE_TOP,    EDGE_LEFT,   EDGE_LEFT};
			4'd14:   e = {EDGE_TOP,    EDGE_LEFT,   EDGE_LEFT,   EDGE_LEFT};
			default: e = '0;
		endcase
		return e;
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/msc_ctrl.sv =====
// controller state machine for the marching squares contour block
// depends on msc_pkg
`default_nettype none

module msc_ctrl (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	input  wire msc_pkg::msc_status_t status,
	output msc_pkg::msc_cmd_t         cmd,
	output logic                      in_stall
);

	msc_pkg::msc_state_t state_q, state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= msc_pkg::ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		case (state_q)
			msc_pkg::ST_IDLE: begin
				if (in_valid) state_nx = msc_pkg::ST_EVAL;
			end
			msc_pkg::ST_EVAL: begin
				state_nx = status.has_seg ? msc_pkg::ST_DLOAD : msc_pkg::ST_IDLE;
			end
			msc_pkg::ST_DLOAD: begin
				state_nx = msc_pkg::ST_DRUN;
			end
			msc_pkg::ST_DRUN: begin
				if (status.div_last)
					state_nx = status.edge_last ? msc_pkg::ST_SEG0 : msc_pkg::ST_DLOAD;
			end
			msc_pkg::ST_SEG0: begin
				if (!status.out_busy)
					state_nx = status.two_seg ? msc_pkg::ST_SEG1 : msc_pkg::ST_IDLE;
			end
			msc_pkg::ST_SEG1: begin
				if (!status.out_busy) state_nx = msc_pkg::ST_IDLE;
			end
			default: state_nx = msc_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_stall = 1'b1;
		case (state_q)
			msc_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				cmd.take = in_valid;
			end
			msc_pkg::ST_EVAL:  cmd.eval = 1'b1;
			msc_pkg::ST_DLOAD: cmd.div_load = 1'b1;
			msc_pkg::ST_DRUN: begin
				cmd.div_step  = 1'b1;
				cmd.div_store = status.div_last;
			end
			msc_pkg::ST_SEG0: cmd.load_seg = !status.out_busy;
			msc_pkg::ST_SEG1: begin
				cmd.load_seg = !status.out_busy;
				cmd.seg_sel  = 1'b1;
			end
			default: in_stall = 1'b1;
		endcase
	end

endmodule

`default_nettype wire

// ===== hw/rtl/msc_dp.sv =====
// datapath: line store, raster position, shared edge divider, output register
// depends on msc_pkg
`default_nettype none

module msc_dp (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire msc_pkg::msc_cmd_t                      cmd,
	output msc_pkg::msc_status_t                        status,
	input  wire logic                                   cfg_valid,
	input  wire logic [msc_pkg::CFG_W-1:0]              cfg_data,
	input  wire logic signed [msc_pkg::SAMP_W-1:0]      sample,
	input  wire logic                                   frame_start,
	output logic                                        out_valid,
	input  wire logic                                   out_stall,
	output logic [msc_pkg::COORD_W-1:0]                 start_x,
	output logic [msc_pkg::COORD_W-1:0]                 start_y,
	output logic [msc_pkg::COORD_W-1:0]                 end_x,
	output logic [msc_pkg::COORD_W-1:0]                 end_y,
	output logic                                        last_segment
);

	localparam int SW = msc_pkg::SAMP_W;
	localparam int CW = msc_pkg::COORD_W;
	localparam int DW = msc_pkg::DEN_W;
	localparam int QW = msc_pkg::CUT_W;

	logic signed [SW-1:0] line_mem [msc_pkg::MAX_WIDTH];

	logic [msc_pkg::CFG_W-1:0] row_width_q;
	logic [msc_pkg::COL_W-1:0] col_q;
	logic [msc_pkg::ROW_W-1:0] row_q;
	logic signed [SW-1:0]      prev_top_q, prev_bot_q, samp_q, above_q;
	logic signed [SW-1:0]      tl_q, tr_q, bl_q, br_q;
	logic [3:0]                code_q;
	logic                      two_seg_q;
	logic [CW-1:0]             x0_q, y0_q;
	msc_pkg::edge_id_t         edge_q;
	logic [DW-1:0]             r_q;
	logic [DW-2:0]             den_q;
	logic                      dz_q;
	logic [QW-1:0]             q_q;
	logic [msc_pkg::STEP_W-1:0] step_q;
	logic [QW-1:0]             cut_q [4];
	logic                      out_valid_q;

	// position and corner code
	logic [msc_pkg::COL_W-1:0] col_use;
	logic [3:0]                code;
	logic                      in_quad;
	logic [msc_pkg::CFG_W-1:0] eff_w, col_inc;

	assign col_use = frame_start ? '0 : col_q;
	assign code    = {~samp_q[SW-1], ~prev_bot_q[SW-1], ~above_q[SW-1], ~prev_top_q[SW-1]};
	assign in_quad = (row_q != '0) && (col_q != '0);
	assign col_inc = {1'b0, col_q} + msc_pkg::CFG_W'(1);

	always_comb begin
		if (row_width_q < msc_pkg::CFG_W'(2))
			eff_w = msc_pkg::CFG_W'(2);
		else if (row_width_q > msc_pkg::CFG_W'(msc_pkg::MAX_WIDTH))
			eff_w = msc_pkg::CFG_W'(msc_pkg::MAX_WIDTH);
		else
			eff_w = row_width_q;
	end

	// divider operand selection
	logic signed [SW-1:0] op_a, op_b;
	logic signed [DW-1:0] a_ext, b_ext, num_s, den_s;

	always_comb begin
		case (edge_q)
			msc_pkg::EDGE_LEFT:  begin op_a = tl_q; op_b = bl_q; end
			msc_pkg::EDGE_TOP:   begin op_a = tl_q; op_b = tr_q; end
			msc_pkg::EDGE_RIGHT: begin op_a = tr_q; op_b = br_q; end
			default:             begin op_a = bl_q; op_b = br_q; end
		endcase
		a_ext = DW'(op_a);
		b_ext = DW'(op_b);
		if (!op_a[SW-1]) begin
			num_s = a_ext;
			den_s = a_ext - b_ext;
		end else begin
			num_s = -a_ext;
			den_s = b_ext - a_ext;
		end
	end

	// one restoring step
	logic [DW-1:0] trial;
	logic          ge;
	logic [QW-1:0] q_next;

	assign trial  = (step_q == '0) ? r_q : {r_q[DW-2:0], 1'b0};
	assign ge     = trial >= {1'b0, den_q};
	assign q_next = {q_q[QW-2:0], ge};

	// endpoint selection
	logic [7:0]        ends;
	msc_pkg::edge_id_t ea, eb;
	logic [CW-1:0]     px [4];
	logic [CW-1:0]     py [4];
	localparam logic [CW-1:0] ONE = CW'(1) << msc_pkg::FRAC_BITS;

	assign ends = msc_pkg::seg_ends(code_q);
	assign ea   = cmd.seg_sel ? ends[3:2] : ends[7:6];
	assign eb   = cmd.seg_sel ? ends[1:0] : ends[5:4];

	always_comb begin
		px[0] = x0_q;                    py[0] = y0_q + CW'(cut_q[0]);
		px[1] = x0_q + CW'(cut_q[1]);    py[1] = y0_q;
		px[2] = x0_q + ONE;              py[2] = y0_q + CW'(cut_q[2]);
		px[3] = x0_q + CW'(cut_q[3]);    py[3] = y0_q + ONE;
	end

	// line store
	always_ff @(posedge clk) begin
		if (cmd.take) above_q <= line_mem[col_use];
		if (cmd.eval) line_mem[col_q] <= samp_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_width_q <= msc_pkg::CFG_W'(msc_pkg::MAX_WIDTH);
			col_q       <= '0;
			row_q       <= '0;
			prev_top_q  <= '0;
			prev_bot_q  <= '0;
			edge_q      <= msc_pkg::EDGE_LEFT;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) row_width_q <= cfg_data;
			if (cmd.take && frame_start) begin
				col_q <= '0;
				row_q <= '0;
			end
			if (cmd.eval) begin
				prev_top_q <= above_q;
				prev_bot_q <= samp_q;
				edge_q     <= msc_pkg::EDGE_LEFT;
				if (col_inc >= eff_w) begin
					col_q <= '0;
					if (row_q < msc_pkg::ROW_W'(msc_pkg::MAX_HEIGHT - 1))
						row_q <= row_q + msc_pkg::ROW_W'(1);
				end else begin
					col_q <= col_inc[msc_pkg::COL_W-1:0];
				end
			end
			if (cmd.div_load) step_q <= '0;
			else if (cmd.div_step) step_q <= step_q + msc_pkg::STEP_W'(1);
			if (cmd.div_store) edge_q <= edge_q + 2'd1;
			if (cmd.load_seg) out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) samp_q <= sample;
		if (cmd.eval) begin
			tl_q      <= prev_top_q;
			tr_q      <= above_q;
			bl_q      <= prev_bot_q;
			br_q      <= samp_q;
			code_q    <= code;
			two_seg_q <= (code == 4'd6) || (code == 4'd9);
			x0_q      <= {col_q - msc_pkg::COL_W'(1), msc_pkg::FRAC_BITS'(0)};
			y0_q      <= {row_q - msc_pkg::ROW_W'(1), msc_pkg::FRAC_BITS'(0)};
		end
		if (cmd.div_load) begin
			r_q   <= num_s;
			den_q <= den_s[DW-2:0];
			dz_q  <= den_s[DW-1] || (den_s == '0);
			q_q   <= '0;
		end else if (cmd.div_step) begin
			r_q <= ge ? trial - {1'b0, den_q} : trial;
			q_q <= q_next;
		end
		if (cmd.div_store) cut_q[edge_q] <= dz_q ? '0 : q_next;
		if (cmd.load_seg) begin
			start_x      <= px[ea];
			start_y      <= py[ea];
			end_x        <= px[eb];
			end_y        <= py[eb];
			last_segment <= cmd.seg_sel || !two_seg_q;
		end
	end

	assign out_valid = out_valid_q;

	always_comb begin
		status.has_seg   = in_quad && (code != 4'd0) && (code != 4'd15);
		status.two_seg   = two_seg_q;
		status.div_last  = step_q == msc_pkg::STEP_W'(msc_pkg::DIV_STEPS - 1);
		status.edge_last = edge_q == msc_pkg::EDGE_BOTTOM;
		status.out_busy  = out_valid_q;
	end

endmodule

`default_nettype wire

// ===== hw/rtl/marching_squares_contour_top.sv =====
// top level of the marching squares contour block
// depends on msc_pkg, msc_ctrl, msc_dp and marching_squares_contour_top_macros.svh
//
//  channel | signals                                   | direction
//  in      | in_valid, in_stall, sample, frame_start   | item in
//  out     | out_valid, out_stall, start/end x/y, last | segment out
//  cfg     | cfg_valid, cfg_ready, cfg_data            | row_width write
//
// a sample that closes no crossed contour cell passes through the take and eval states only
// a crossed cell then computes the left, top, right and bottom edge cuts in turn on one shared restoring divider
// and loads each segment into the output register; a saddle's second waits for the first
// reset clears position, previous-column corners and row_width (1024); the line store is not cleared
// output stall holds only the segment load; a new item may enter once loads are done
`default_nettype none
`include "marching_squares_contour_top_macros.svh"

module marching_squares_contour_top (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic [msc_pkg::CFG_W-1:0]         cfg_data,
	input  wire logic                              in_valid,
	output logic                                   in_stall,
	input  wire logic signed [msc_pkg::SAMP_W-1:0] sample,
	input  wire logic                              frame_start,
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output logic [msc_pkg::COORD_W-1:0]            start_x,
	output logic [msc_pkg::COORD_W-1:0]            start_y,
	output logic [msc_pkg::COORD_W-1:0]            end_x,
	output logic [msc_pkg::COORD_W-1:0]            end_y,
	output logic                                   last_segment
);

	msc_pkg::msc_cmd_t    cmd;
	msc_pkg::msc_status_t status;

	assign cfg_ready = 1'b1;

	msc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.status   (status),
		.cmd      (cmd),
		.in_stall (in_stall)
	);

	msc_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.cfg_valid    (cfg_valid && cfg_ready),
		.cfg_data     (cfg_data),
		.sample       (sample),
		.frame_start  (frame_start),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.start_x      (start_x),
		.start_y      (start_y),
		.end_x        (end_x),
		.end_y        (end_y),
		.last_segment (last_segment)
	);

	`MSC_ASSERT_NEXT(a_busy_after_take, in_valid && !in_stall, in_stall)
	`MSC_ASSERT_NEXT(a_no_seg_after_last, out_valid && !out_stall && last_segment, !out_valid)
	`MSC_ASSERT_NOW(a_load_only_when_free, cmd.load_seg, !out_valid)

endmodule

`default_nettype wire

// ===== bench/tb_marching_squares_contour_top.sv =====
// self-checking bench for marching_squares_contour_top: streams raster samples,
// predicts every contour segment in-line and checks each output item in order
// depends on msc_pkg and the marching_squares_contour_top rtl
`default_nettype none

module tb_marching_squares_contour_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int COORD_W    = msc_pkg::COORD_W;
	localparam int CFG_W      = msc_pkg::CFG_W;
	localparam int SAMP_W     = msc_pkg::SAMP_W;
	localparam int MAX_WIDTH  = msc_pkg::MAX_WIDTH;
	localparam int MAX_HEIGHT = msc_pkg::MAX_HEIGHT;
	localparam int FRAC_BITS  = msc_pkg::FRAC_BITS;

	localparam int IDLE_LIMIT = 5000;
	localparam int DRAIN_CYCLES = 60;
	localparam int NO_IDLE = 0, SEND_IDLE = 1, RECV_IDLE = 2, BOTH_IDLE = 3;

	// endpoint edge pairs of each code's segments, first segment in the top bits
	localparam logic [7:0] CELL_ENDS [16] = '{
		8'h00, 8'h10, 8'h60, 8'h20, 8'hC0, 8'hD0, 8'h4E, 8'hE0,
		8'hB0, 8'h1B, 8'h70, 8'h30, 8'h80, 8'h90, 8'h40, 8'h00};

	typedef struct {
		logic [COORD_W-1:0] sx, sy, ex, ey;
		logic last;
	} segment_t;

	logic clk, arst_n;
	logic cfg_valid, cfg_ready;
	logic [CFG_W-1:0] cfg_data;
	logic in_valid, in_stall;
	logic signed [SAMP_W-1:0] sample;
	logic frame_start;
	logic out_valid, out_stall;
	logic [COORD_W-1:0] start_x, start_y, end_x, end_y;
	logic last_segment;

	marching_squares_contour_top dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall), .sample(sample),
		.frame_start(frame_start),
		.out_valid(out_valid), .out_stall(out_stall),
		.start_x(start_x), .start_y(start_y), .end_x(end_x), .end_y(end_y),
		.last_segment(last_segment)
	);

	segment_t pending_segments[$];
	logic signed [SAMP_W-1:0] row_mem [MAX_WIDTH];
	bit row_written [MAX_WIDTH];
	logic signed [SAMP_W-1:0] corner_top, corner_bottom;
	int col_pos, row_pos;
	logic [CFG_W-1:0] width_reg;
	int idle_mode;
	int mismatches, samples_sent, segments_seen, idle_count;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic int edge_cut(int a, int b);
		int num, den;
		if (a >= 0) begin
			num = a;
			den = a - b;
		end else begin
			num = -a;
			den = b - a;
		end
		if (den <= 0)
			return 0;
		return (num << FRAC_BITS) / den;
	endfunction

	task automatic trace_cell(input logic signed [SAMP_W-1:0] s, input logic fs);
		int width, x0, y0, n, code;
		int px[4], py[4];
		int tl, tr, bl, br;
		logic [1:0] ea, eb;
		logic signed [SAMP_W-1:0] above;
		segment_t seg;
		width = width_reg;
		if (width < 2)
			width = 2;
		if (width > MAX_WIDTH)
			width = MAX_WIDTH;
		if (fs) begin
			col_pos = 0;
			row_pos = 0;
		end
		above = row_mem[col_pos];
		if (row_pos > 0 && col_pos > 0) begin
			tl = corner_top;
			tr = above;
			bl = corner_bottom;
			br = s;
			code = int'(tl >= 0) | (int'(tr >= 0) << 1) | (int'(bl >= 0) << 2) |
				(int'(br >= 0) << 3);
			x0 = (col_pos - 1) << FRAC_BITS;
			y0 = (row_pos - 1) << FRAC_BITS;
			px[msc_pkg::EDGE_LEFT] = x0;
			py[msc_pkg::EDGE_LEFT] = y0 + edge_cut(tl, bl);
			px[msc_pkg::EDGE_TOP] = x0 + edge_cut(tl, tr);
			py[msc_pkg::EDGE_TOP] = y0;
			px[msc_pkg::EDGE_RIGHT] = x0 + (1 << FRAC_BITS);
			py[msc_pkg::EDGE_RIGHT] = y0 + edge_cut(tr, br);
			px[msc_pkg::EDGE_BOTTOM] = x0 + edge_cut(bl, br);
			py[msc_pkg::EDGE_BOTTOM] = y0 + (1 << FRAC_BITS);
			n = (code == 0 || code == 15) ? 0 : (code == 6 || code == 9) ? 2 : 1;
			for (int k = 0; k < n; k++) begin
				ea = CELL_ENDS[code][7 - 4 * k -: 2];
				eb = CELL_ENDS[code][5 - 4 * k -: 2];
				seg.sx = COORD_W'(px[ea]);
				seg.sy = COORD_W'(py[ea]);
				seg.ex = COORD_W'(px[eb]);
				seg.ey = COORD_W'(py[eb]);
				seg.last = (k == n - 1);
				pending_segments = {pending_segments, seg};
			end
		end
		corner_top = above;
		row_mem[col_pos] = s;
		row_written[col_pos] = 1'b1;
		corner_bottom = s;
		col_pos++;
		if (col_pos >= width) begin
			col_pos = 0;
			if (row_pos < MAX_HEIGHT - 1)
				row_pos++;
		end
	endtask

	task automatic send_sample(input logic signed [SAMP_W-1:0] s, input logic fs);
		logic f;
		// never read a line store entry that was not written
		f = fs || (row_pos > 0 && !row_written[col_pos]);
		@(negedge clk);
		in_valid <= 1'b1;
		sample <= s;
		frame_start <= f;
		do @(posedge clk); while (in_stall);
		trace_cell(s, f);
		samples_sent++;
	endtask

	task automatic idle_input(input int n);
		@(negedge clk);
		in_valid <= 1'b0;
		repeat (n - 1) @(negedge clk);
	endtask

	task automatic drain();
		idle_input(1);
		wait (pending_segments.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_row_width(input logic [CFG_W-1:0] v);
		drain();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		width_reg = v;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic maybe_gap();
		if ((idle_mode == SEND_IDLE && $urandom_range(99) < 56) ||
			(idle_mode == BOTH_IDLE && $urandom_range(99) < 21))
			idle_input($urandom_range(1, 4));
	endtask

	function automatic logic signed [SAMP_W-1:0] rand_sample();
		case ($urandom_range(3))
			0: return SAMP_W'($urandom);
			1: return $signed(SAMP_W'($urandom_range(64))) - 16'sd32;
			2: return $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
			default: return $signed(SAMP_W'($urandom_range(4000))) - 16'sd2000;
		endcase
	endfunction

	function automatic logic signed [SAMP_W-1:0] corner_value(input bit inside_c);
		if (inside_c)
			case ($urandom_range(3))
				0: return 16'sd0;
				1: return 16'sh7FFF;
				2: return 16'sd1;
				default: return SAMP_W'($urandom_range(32767));
			endcase
		return $urandom_range(1) ? 16'sh8000 : 16'sh8000 | SAMP_W'($urandom);
	endfunction

	always @(negedge clk) begin
		if (idle_mode == RECV_IDLE)
			out_stall <= $urandom_range(99) < 56;
		else if (idle_mode == BOTH_IDLE)
			out_stall <= $urandom_range(99) < 21;
		else
			out_stall <= 1'b0;
	end

	always @(posedge clk) begin
		segment_t want;
		if (out_valid && !out_stall) begin
			segments_seen++;
			if (pending_segments.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected segment %h %h %h %h last %b",
						start_x, start_y, end_x, end_y, last_segment);
			end else begin
				want = pending_segments.pop_front();
				if (want.sx !== start_x || want.sy !== start_y || want.ex !== end_x ||
					want.ey !== end_y || want.last !== last_segment) begin
					mismatches++;
					if (mismatches <= 10)
						$display("expected %h %h %h %h %b got %h %h %h %h %b",
							want.sx, want.sy, want.ex, want.ey, want.last,
							start_x, start_y, end_x, end_y, last_segment);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			idle_count = 0;
		else if (arst_n)
			idle_count++;
		if (idle_count >= IDLE_LIMIT) begin
			$display("watchdog: no item accepted for %0d cycles", IDLE_LIMIT);
			$display("FAIL marching_squares_contour_top");
			$finish;
		end
	end

	// walk over all 16 corner codes with width 2, extreme corner values
	task automatic test_all_cell_codes();
		int walk[17] = '{0, 0, 1, 1, 2, 2, 3, 3, 0, 2, 0, 3, 1, 3, 2, 1, 0};
		set_row_width(CFG_W'(2));
		for (int r = 0; r < 17; r++) begin
			send_sample(corner_value(walk[r][0]), r == 0);
			send_sample(corner_value(walk[r][1]), 1'b0);
		end
	endtask

	task automatic test_width_limits();
		logic [CFG_W-1:0] widths[4] = '{0, 1, 11'd1025, 11'd2047};
		foreach (widths[i]) begin
			set_row_width(widths[i]);
			for (int k = 0; k < 6; k++)
				send_sample(rand_sample(), k == 0);
		end
	endtask

	task automatic test_width_shrink_mid_row();
		set_row_width(CFG_W'(8));
		for (int k = 0; k < 21; k++)
			send_sample(rand_sample(), k == 0);
		set_row_width(CFG_W'(3));
		for (int k = 0; k < 12; k++)
			send_sample(rand_sample(), 1'b0);
	endtask

	task automatic test_random_stream(input int mode, input int count);
		int pause_at;
		set_row_width(CFG_W'($urandom_range(99) < 80 ? $urandom_range(2, 12) :
			$urandom_range(0, 2047)));
		idle_mode = mode;
		pause_at = $urandom_range(count / 4, count * 3 / 4);
		for (int k = 0; k < count; k++) begin
			if (k == pause_at) begin
				idle_input(1);
				wait (pending_segments.size() == 0);
			end
			if (k == count / 2)
				set_row_width(CFG_W'($urandom_range(2, 16)));
			maybe_gap();
			send_sample(rand_sample(), k == 0 || $urandom_range(99) < 2);
		end
		drain();
		idle_mode = NO_IDLE;
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		in_valid = 1'b0;
		sample = '0;
		frame_start = 1'b0;
		mismatches = 0;
		samples_sent = 0;
		segments_seen = 0;
		idle_count = 0;
		idle_mode = NO_IDLE;
		width_reg = 11'd1024;
		col_pos = 0;
		row_pos = 0;
		corner_top = '0;
		corner_bottom = '0;
		foreach (row_written[i]) begin
			row_written[i] = 1'b0;
			row_mem[i] = '0;
		end
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_all_cell_codes();
		test_width_limits();
		test_width_shrink_mid_row();
		test_random_stream(NO_IDLE, 215);
		test_random_stream(SEND_IDLE, 215);
		test_random_stream(RECV_IDLE, 215);
		test_random_stream(BOTH_IDLE, 215);
		drain();

		if (pending_segments.size() != 0) begin
			mismatches++;
			$display("%0d expected segments never arrived", pending_segments.size());
		end
		$display("covered all 16 corner codes, width clamping, mid-row shrink, four idle phases");
		$display("%0d samples in, %0d segments out, %0d mismatches",
			samples_sent, segments_seen, mismatches);
		if (mismatches == 0)
			$display("PASS marching_squares_contour_top");
		else
			$display("FAIL marching_squares_contour_top");
		$finish;
	end

endmodule

`default_nettype wire
